// ----- design/sia_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package sia_pkg;

    localparam int INT_BITS  = 15;
    localparam int MODE_BITS = 5;
    localparam int FAIL_BITS = 3;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_ADD    = 5'd0,
        MODE_SUB    = 5'd1,
        MODE_LT     = 5'd2,
        MODE_GT     = 5'd3,
        MODE_LE     = 5'd4,
        MODE_GE     = 5'd5,
        MODE_EQ     = 5'd6,
        MODE_NE     = 5'd7,
        MODE_MUL    = 5'd8,
        MODE_DIVIDE = 5'd9,
        MODE_MOD    = 5'd10,
        MODE_DIV    = 5'd11,
        MODE_QUO    = 5'd12,
        MODE_AND    = 5'd13,
        MODE_OR     = 5'd14,
        MODE_XOR    = 5'd15,
        MODE_SHIFT  = 5'd16
    } t_mode;

    typedef enum logic [FAIL_BITS-1:0] {
        FAIL_OK      = 3'd0,
        FAIL_RANGE   = 3'd1,
        FAIL_ZERO    = 3'd2,
        FAIL_INEXACT = 3'd3,
        FAIL_MODE    = 3'd4
    } t_fail;

    // Operation class decided by the front end.
    typedef enum logic [2:0] {
        CLS_BAD,
        CLS_ARITH,
        CLS_CMP,
        CLS_MUL,
        CLS_DIV,
        CLS_LOGIC,
        CLS_SHIFT
    } t_class;

    typedef struct packed {
        logic [MODE_BITS-1:0]       mode;
        logic signed [INT_BITS-1:0] receiver;
        logic signed [INT_BITS-1:0] argument;
    } t_in;

    typedef struct packed {
        logic signed [INT_BITS-1:0] int_value;
        logic                       is_boolean;
        logic                       truth;
        logic [FAIL_BITS-1:0]       fail_code;
    } t_out;

endpackage
`default_nettype wire

// ----- design/sia_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sia_front
    import sia_pkg::*;
(
    input  wire  logic                       i_clk,
    input  wire  logic                       i_rst_n,
    input  wire  logic                       i_valid,
    output logic                             o_ready,
    input  wire  logic [MODE_BITS-1:0]       i_mode,
    input  wire  logic signed [INT_BITS-1:0] i_a,
    input  wire  logic signed [INT_BITS-1:0] i_b,
    output logic                             o_valid,
    input  wire  logic                       i_ready,
    output t_class                           o_cls,
    output logic [MODE_BITS-1:0]             o_mode,
    output logic signed [INT_BITS-1:0]       o_a,
    output logic signed [INT_BITS-1:0]       o_b
);
    // Two-entry queue between the decode and execute sides.
    typedef struct packed {
        t_class                     cls;
        logic [MODE_BITS-1:0]       mode;
        logic signed [INT_BITS-1:0] a;
        logic signed [INT_BITS-1:0] b;
    } t_qent;

    t_qent         r_q [2];
    t_qent         head;
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    t_class        cls;
    logic          push, pop;

    always_comb begin
        priority if (i_mode > MODE_BITS'(MODE_SHIFT)) cls = CLS_BAD;
        else if (i_mode == MODE_BITS'(MODE_ADD) || i_mode == MODE_BITS'(MODE_SUB))
            cls = CLS_ARITH;
        else if (i_mode <= MODE_BITS'(MODE_NE)) cls = CLS_CMP;
        else if (i_mode == MODE_BITS'(MODE_MUL)) cls = CLS_MUL;
        else if (i_mode <= MODE_BITS'(MODE_QUO)) cls = CLS_DIV;
        else if (i_mode <= MODE_BITS'(MODE_XOR)) cls = CLS_LOGIC;
        else cls = CLS_SHIFT;
    end

    assign o_ready = (r_cnt != 2'd2);
    assign push    = i_valid && o_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && i_ready;
    assign head    = r_q[r_rp];
    assign o_cls   = head.cls;
    assign o_mode  = head.mode;
    assign o_a     = head.a;
    assign o_b     = head.b;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{cls: cls, mode: i_mode, a: i_a, b: i_b};
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

// ----- design/sia_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sia_back
    import sia_pkg::*;
(
    input  wire  logic                       i_clk,
    input  wire  logic                       i_rst_n,
    input  wire  logic                       i_valid,
    output logic                             o_ready,
    input  wire  t_class                     i_cls,
    input  wire  logic [MODE_BITS-1:0]       i_mode,
    input  wire  logic signed [INT_BITS-1:0] i_a,
    input  wire  logic signed [INT_BITS-1:0] i_b,
    output logic                             o_valid,
    input  wire  logic                       i_ready,
    output logic signed [INT_BITS-1:0]       o_value,
    output logic                             o_isb,
    output logic                             o_truth,
    output logic [FAIL_BITS-1:0]             o_fail
);
    localparam int N  = INT_BITS;
    localparam int W  = N + 1;          // magnitude width, holds 2^(N-1)
    localparam int SB = $clog2(N + 1);
    localparam int NS = N + 2;          // stages: decode + N divider steps + finish

    typedef struct packed {
        logic                 v;
        t_class               cls;
        logic [MODE_BITS-1:0] mode;
        logic signed [N-1:0]  a;
        logic signed [N-1:0]  b;
        logic [W-1:0]         rem;      // partial remainder (|a| domain)
        logic [W-1:0]         quo;      // quotient bits / dividend shift
        logic [W-1:0]         dvs;      // |b|
        logic signed [N+1:0]  res;      // result of non-divide ops
        logic [FAIL_BITS-1:0] fail;
        logic                 isb;
        logic                 truth;
    } t_stage;

    t_stage r_s [NS];
    t_stage s0;
    logic   adv;

    // Output register plus pipeline: stall the whole line when the output is blocked.
    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;

    // Decode stage: every op but the divide family is computed here; the finish stage range-checks results.
    logic signed [2*N-1:0] prod;
    logic signed [N:0]     sa, sb2;
    logic [N-1:0]          mag_a;
    logic [SB-1:0]         sh;
    logic signed [N:0]     big;
    logic                  lt;
    always_comb begin
        s0       = '0;
        s0.v     = i_valid;
        s0.cls   = i_cls;
        s0.mode  = i_mode;
        s0.a     = i_a;
        s0.b     = i_b;
        // Dividend sits one bit up so N steps consume all N magnitude bits.
        mag_a    = i_a[N-1] ? N'(-i_a) : N'(i_a);
        s0.quo   = {mag_a, 1'b0};
        s0.dvs   = i_b[N-1] ? W'(-{i_b[N-1], i_b}) : W'(i_b);
        s0.fail  = FAIL_OK;
        sa       = {i_a[N-1], i_a};
        sb2      = {i_b[N-1], i_b};
        prod     = i_a * i_b;
        lt       = i_a < i_b;
        sh       = '0;
        big      = '0;
        unique case (i_cls)
            CLS_BAD: s0.fail = FAIL_MODE;
            CLS_ARITH: begin
                s0.res = (i_mode == MODE_BITS'(MODE_ADD)) ? (N+2)'(sa + sb2)
                                                         : (N+2)'(sa - sb2);
            end
            CLS_CMP: begin
                s0.isb = 1'b1;
                unique case (i_mode)
                    MODE_BITS'(MODE_LT): s0.truth = lt;
                    MODE_BITS'(MODE_GT): s0.truth = !lt && (i_a != i_b);
                    MODE_BITS'(MODE_LE): s0.truth = lt || (i_a == i_b);
                    MODE_BITS'(MODE_GE): s0.truth = !lt;
                    MODE_BITS'(MODE_EQ): s0.truth = (i_a == i_b);
                    default:             s0.truth = (i_a != i_b);
                endcase
            end
            CLS_MUL: begin
                // Fits only if the upper bits are all sign copies.
                if (prod[2*N-1:N-1] != '0 && prod[2*N-1:N-1] != '1) s0.fail = FAIL_RANGE;
                else s0.res = (N+2)'(signed'(prod[N-1:0]));
            end
            CLS_DIV: begin
                if (i_b == '0) s0.fail = FAIL_ZERO;
            end
            CLS_LOGIC: begin
                unique case (i_mode)
                    MODE_BITS'(MODE_AND): s0.res = (N+2)'(i_a & i_b);
                    MODE_BITS'(MODE_OR):  s0.res = (N+2)'(i_a | i_b);
                    default:              s0.res = (N+2)'(i_a ^ i_b);
                endcase
            end
            default: begin // shift
                if (!i_b[N-1]) begin
                    if (i_a == '0) s0.res = '0;
                    else if (i_b >= N) s0.fail = FAIL_RANGE;
                    else begin
                        sh  = SB'(i_b);
                        big = sa <<< sh;
                        if ((big >>> sh) != sa || big[N] != big[N-1]) s0.fail = FAIL_RANGE;
                        else s0.res = (N+2)'(big);
                    end
                end else begin
                    if (sb2 <= -(N+1)'(N)) s0.res = i_a[N-1] ? '1 : '0;
                    else begin
                        sh     = SB'(-sb2);
                        s0.res = (N+2)'(sa >>> sh);
                    end
                end
            end
        endcase
    end

    // Divider steps: one restoring step per stage, MSB of |a| first.
    t_stage n_s [N+1];
    always_comb begin
        logic [W:0] trial;
        n_s[0] = s0;
        for (int k = 1; k < N + 1; k++) begin
            n_s[k] = r_s[k-1];
            trial  = {r_s[k-1].rem, r_s[k-1].quo[W-1]};
            n_s[k].quo = {r_s[k-1].quo[W-2:0], 1'b0};
            if (trial >= {1'b0, r_s[k-1].dvs}) begin
                n_s[k].rem    = W'(trial - {1'b0, r_s[k-1].dvs});
                n_s[k].quo[0] = 1'b1;
            end else begin
                n_s[k].rem = W'(trial);
            end
        end
    end

    // Finish: sign-correct quotient and remainder, apply floor rules, range-check and clear failed results.
    t_stage f;
    logic signed [N+1:0] q, r;
    logic                differ;
    always_comb begin
        f      = r_s[N];
        q      = (f.a[N-1] ^ f.b[N-1]) ? -(N+2)'(f.quo) : (N+2)'(f.quo);
        r      = f.a[N-1] ? -(N+2)'(f.rem) : (N+2)'(f.rem);
        differ = (f.rem != '0) && (f.a[N-1] != f.b[N-1]);
        if (f.cls == CLS_DIV && f.fail == FAIL_OK) begin
            unique case (f.mode)
                MODE_BITS'(MODE_DIVIDE): begin
                    f.res = q;
                    if (f.rem != '0) f.fail = FAIL_INEXACT;
                end
                MODE_BITS'(MODE_MOD): f.res = differ ? r + (N+2)'(f.b) : r;
                MODE_BITS'(MODE_DIV): f.res = differ ? q - (N+2)'(1) : q;
                default:              f.res = q;
            endcase
        end
        if (f.fail == FAIL_OK && !f.isb &&
            (f.res > (N+2)'((1 <<< (N-1)) - 1) || f.res < -(N+2)'(1 <<< (N-1))))
            f.fail = FAIL_RANGE;
        if (f.fail != FAIL_OK) begin
            f.res   = '0;
            f.isb   = 1'b0;
            f.truth = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) r_s[k].v <= 1'b0;
        end else if (adv) begin
            for (int k = 0; k < N + 1; k++) r_s[k] <= n_s[k];
            r_s[N+1] <= f;
        end
    end

    assign o_valid = r_s[N+1].v;
    assign o_value = N'(r_s[N+1].res);
    assign o_isb   = r_s[N+1].isb;
    assign o_truth = r_s[N+1].truth;
    assign o_fail  = r_s[N+1].fail;
endmodule
`default_nettype wire

// ----- design/small_integer_alu_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel | Direction | Handshake              | Beat
// in      | input     | i_in_valid/o_in_ready  | t_in  {mode, receiver, argument}
// out     | output    | o_out_valid/i_out_ready| t_out {int_value, is_boolean, truth, fail_code}
//
// One beat per cycle sustained while the output is not stalled. From input accept
// to output, a beat passes through the queue, the decode stage, INT_BITS
// restoring divider steps, then a finish stage that also serves as the output
// register.
// i_rst_n is synchronous, active low, and empties the queue and the pipeline.
// A stalled output freezes the execute pipeline; the two-entry queue then
// fills and drops o_in_ready.
module small_integer_alu_core
    import sia_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out
);
    t_in  in_beat;
    t_out out_beat;
    assign in_beat = i_in;
    assign o_out   = out_beat;

    logic                       q_valid, q_ready;
    t_class                     q_cls;
    logic [MODE_BITS-1:0]       q_mode;
    logic signed [INT_BITS-1:0] q_a, q_b;

    // Front: classify and queue.
    sia_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_mode  (in_beat.mode),
        .i_a     (in_beat.receiver),
        .i_b     (in_beat.argument),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_cls   (q_cls),
        .o_mode  (q_mode),
        .o_a     (q_a),
        .o_b     (q_b)
    );

    // Back: execute, divide over a step pipeline, hold the result.
    sia_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_cls   (q_cls),
        .i_mode  (q_mode),
        .i_a     (q_a),
        .i_b     (q_b),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_value (out_beat.int_value),
        .o_isb   (out_beat.is_boolean),
        .o_truth (out_beat.truth),
        .o_fail  (out_beat.fail_code)
    );
endmodule
`default_nettype wire

// ----- bench/small_integer_alu_core_test.sv -----
`timescale 1ns / 1ps
module small_integer_alu_core_test;
    import sia_pkg::*;

    localparam int LATENCY = INT_BITS + 2;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 1950;
    localparam longint MAX_INT = (64'sd1 <<< (INT_BITS - 1)) - 1;
    localparam longint MIN_INT = -MAX_INT - 1;

    // Beat layouts come from the package.
    typedef t_in  t_op_beat;
    typedef t_out t_answer_beat;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_op_beat i_in;
    logic o_out_valid;
    logic i_out_ready;
    t_answer_beat o_out;

    small_integer_alu_core dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in(i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out(o_out)
    );

    t_op_beat     pending_ops[$];
    t_answer_beat expected_answers[$];
    int           error_count = 0;
    int           cycle_count = 0;
    int           drain_at = -1;    // op index at which the sender waits for a full drain
    int           sent_count = 0;
    bit           stimulus_done = 0;

    // Compute the answer the primitive unit must give for one operation.
    function automatic t_answer_beat primitive_answer(t_op_beat op);
        t_answer_beat ans;
        longint a, b, q, r, res;
        t_fail fail;
        bit truth_bit;
        a = longint'(op.receiver);
        b = longint'(op.argument);
        res = 0;
        fail = FAIL_OK;
        truth_bit = 0;
        ans = '0;
        case (op.mode)
            MODE_LT: truth_bit = a < b;
            MODE_GT: truth_bit = a > b;
            MODE_LE: truth_bit = a <= b;
            MODE_GE: truth_bit = a >= b;
            MODE_EQ: truth_bit = a == b;
            MODE_NE: truth_bit = a != b;
            MODE_ADD: res = a + b;
            MODE_SUB: res = a - b;
            MODE_MUL: res = a * b;
            MODE_AND: res = a & b;
            MODE_OR:  res = a | b;
            MODE_XOR: res = a ^ b;
            MODE_DIVIDE, MODE_MOD, MODE_DIV, MODE_QUO: begin
                if (b == 0) begin
                    fail = FAIL_ZERO;
                end else begin
                    q = a / b;
                    r = a % b;
                    if (op.mode == MODE_DIVIDE) begin
                        if (r != 0) fail = FAIL_INEXACT;
                        res = q;
                    end else if (op.mode == MODE_QUO) begin
                        res = q;
                    end else if (r != 0 && ((r < 0) != (b < 0))) begin
                        // floor rounding: step the quotient down, pull the remainder over
                        res = (op.mode == MODE_MOD) ? r + b : q - 1;
                    end else begin
                        res = (op.mode == MODE_MOD) ? r : q;
                    end
                end
            end
            MODE_SHIFT: begin
                if (b >= 0) begin
                    if (a == 0) res = 0;
                    else if (b >= INT_BITS) fail = FAIL_RANGE;
                    else res = a <<< b;
                end else if (-b >= INT_BITS) begin
                    res = (a < 0) ? -1 : 0;
                end else begin
                    res = a >>> (-b);
                end
            end
            default: fail = FAIL_MODE;
        endcase
        if (fail == FAIL_OK && (res < MIN_INT || res > MAX_INT)) fail = FAIL_RANGE;
        if (fail != FAIL_OK) begin
            ans.fail_code = fail;
        end else if (op.mode >= MODE_LT && op.mode <= MODE_NE) begin
            ans.is_boolean = 1'b1;
            ans.truth = truth_bit;
        end else begin
            ans.int_value = res[INT_BITS-1:0];
        end
        return ans;
    endfunction

    function automatic logic [INT_BITS-1:0] pick_operand();
        case ($urandom_range(0, 5))
            0: return MIN_INT[INT_BITS-1:0];
            1: return MAX_INT[INT_BITS-1:0];
            2: return INT_BITS'($urandom_range(0, 40) - 20);
            3: return INT_BITS'($urandom_range(0, 400) - 200);
            default: return INT_BITS'($urandom);
        endcase
    endfunction

    task automatic add_op(logic [MODE_BITS-1:0] mode, longint rcv, longint arg);
        t_op_beat op;
        op.mode = mode;
        op.receiver = rcv[INT_BITS-1:0];
        op.argument = arg[INT_BITS-1:0];
        pending_ops.push_back(op);
    endtask

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // Hold reset, then release it and fill the op queue.
    initial begin
        t_op_beat op;
        int k;
        i_rst_n = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: extremes, every mode, the corner cases.
        add_op(MODE_ADD, MAX_INT, 1);
        add_op(MODE_SUB, MIN_INT, 1);
        add_op(MODE_ADD, MIN_INT, MAX_INT);
        add_op(MODE_LT, MIN_INT, MAX_INT);
        add_op(MODE_GT, MIN_INT, MAX_INT);
        add_op(MODE_LE, 5, 5);
        add_op(MODE_GE, -1, 0);
        add_op(MODE_EQ, MAX_INT, MAX_INT);
        add_op(MODE_NE, 3, 3);
        add_op(MODE_MUL, MIN_INT, -1);
        add_op(MODE_MUL, -128, 128);
        add_op(MODE_DIVIDE, 12, 0);
        add_op(MODE_DIVIDE, 12, 5);
        add_op(MODE_DIVIDE, -12, 4);
        add_op(MODE_MOD, -7, 2);
        add_op(MODE_DIV, 7, -2);
        add_op(MODE_QUO, MIN_INT, -1);
        add_op(MODE_AND, -1, MIN_INT);
        add_op(MODE_OR, MAX_INT, MIN_INT);
        add_op(MODE_XOR, -1, MAX_INT);
        add_op(MODE_SHIFT, 0, 40);
        add_op(MODE_SHIFT, 1, INT_BITS);
        add_op(MODE_SHIFT, -1, INT_BITS - 1);
        add_op(MODE_SHIFT, MIN_INT, -INT_BITS);
        add_op(5'd17, 1, 1);
        add_op(5'd31, -1, -1);
        drain_at = pending_ops.size();

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            op.receiver = pick_operand();
            op.argument = pick_operand();
            if ($urandom_range(0, 15) == 0) op.mode = MODE_BITS'($urandom_range(17, 31));
            else op.mode = MODE_BITS'($urandom_range(MODE_ADD, MODE_SHIFT));
            // Bias toward exact divides and shifts that land in range.
            if (op.mode == MODE_DIVIDE && $urandom_range(0, 1))
                op.receiver = INT_BITS'(op.argument * ($urandom_range(0, 6) - 3));
            if (op.mode == MODE_SHIFT && $urandom_range(0, 2) != 0)
                op.argument = INT_BITS'($urandom_range(0, 2 * INT_BITS + 4) - INT_BITS - 2);
            pending_ops.push_back(op);
        end
        stimulus_done = 1;
    end

    // Driver: bursts of beats, sometimes separated by random gaps.
    int  burst_left = 0;
    int  gap_left = 0;
    always @(posedge i_clk) begin
        logic next_valid;
        t_op_beat next_op;
        if (!i_rst_n) begin
            i_in_valid <= 0;
            i_in <= '0;
        end else begin
            next_valid = i_in_valid;
            next_op = i_in;
            if (i_in_valid && o_in_ready) begin
                // beat taken: predict its answer and advance
                expected_answers.push_back(primitive_answer(i_in));
                sent_count <= sent_count + 1;
                void'(pending_ops.pop_front());
                next_valid = 0;
                if (burst_left > 0) burst_left = burst_left - 1;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                end else if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    if ($urandom_range(0, 2) == 0) gap_left = $urandom_range(1, 8);
                end else if (pending_ops.size() > 0 &&
                             !((sent_count + (i_in_valid && o_in_ready)) == drain_at &&
                               (expected_answers.size() > 0 || o_out_valid))) begin
                    // hold at drain_at until everything in flight has come back
                    next_valid = 1;
                    next_op = pending_ops[0];
                end
            end
            i_in_valid <= next_valid;
            i_in <= next_op;
        end
    end

    // Receiver: stall pattern switches between no stalls, light and heavy.
    int stall_style = 0;
    always @(posedge i_clk) begin
        t_answer_beat want;
        if (!i_rst_n) begin
            i_out_ready <= 0;
        end else begin
            if ($urandom_range(0, 99) == 0) stall_style = $urandom_range(0, 2);
            case (stall_style)
                0: i_out_ready <= 1;
                1: i_out_ready <= ($urandom_range(0, 3) != 0);
                default: i_out_ready <= ($urandom_range(0, 3) == 0);
            endcase
            if (o_out_valid && i_out_ready) begin
                if (expected_answers.size() == 0) begin
                    $display("%0t: unexpected beat %p", $time, o_out);
                    error_count++;
                end else begin
                    want = expected_answers.pop_front();
                    if (o_out.int_value !== want.int_value ||
                        o_out.is_boolean !== want.is_boolean ||
                        o_out.truth !== want.truth ||
                        o_out.fail_code !== want.fail_code) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, o_out);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        wait (stimulus_done);
        wait (pending_ops.size() == 0 && expected_answers.size() == 0);
        repeat (LATENCY * 2) @(posedge i_clk);
        if (error_count == 0 && expected_answers.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
